// ===== rtl/speech_param_fifo_host_port_core_defines.svh =====
// Assertion helpers for the speech parameter port core.
// Both forms sample on clk_i and are disabled while rst_ni is low.
`ifndef SPEECH_PARAM_FIFO_HOST_PORT_CORE_DEFINES_SVH
`define SPEECH_PARAM_FIFO_HOST_PORT_CORE_DEFINES_SVH
`ifndef SYNTH
// Consequent checked in the same cycle as the antecedent.
`define SPFH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spfh: same-cycle check failed");
// Consequent checked in the cycle after the antecedent.
`define SPFH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spfh: next-cycle check failed");
`else
`define SPFH_ASSERT_NOW(lbl, ante, cons)
`define SPFH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/spfh_pkg.sv =====
`timescale 1ns / 1ps
package spfh_pkg;

  localparam int FRAME_BYTES  = 7;
  localparam int RESET_FRAMES = 7;
  localparam int SLOT_W       = $clog2(FRAME_BYTES);
  localparam int FETCH_MIN    = 6;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_BYTES - 1);

  localparam logic [7:0] CMD_START   = 8'hfe;
  localparam logic [7:0] CMD_STOP    = 8'hff;
  localparam logic [7:0] REPEAT_MASK = 8'hf8;

  typedef enum logic [1:0] {
    OP_DATA   = 2'd0,
    OP_CMD    = 2'd1,
    OP_STATUS = 2'd2,
    OP_FETCH  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    RES_OK       = 3'd0,
    RES_NOT_BUSY = 3'd1,
    RES_FULL     = 3'd2,
    RES_FRAME    = 3'd3,
    RES_SILENT   = 3'd4,
    RES_END      = 3'd5,
    RES_ERROR    = 3'd6
  } res_e;

  typedef enum logic [1:0] {
    PUT_HEAD = 2'd0,
    PUT_ZERO = 2'd1,
    PUT_BYTE = 2'd2
  } put_sel_e;

  typedef enum logic [1:0] {
    VAL_ZERO   = 2'd0,
    VAL_STATUS = 2'd1,
    VAL_FRAME  = 2'd2
  } val_sel_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0] result_code;
    logic [7:0] value;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic              cap;
    logic              put;
    put_sel_e          put_sel;
    logic              idx_step;
    logic              cmd_apply;
    logic              rd;
    logic              pop;
    logic [SLOT_W-1:0] slot;
    logic              flush_err;
    logic              end_clr;
    logic              out_load;
    res_e              out_code;
    val_sel_e          val_sel;
    logic              out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       busy;
    logic       full;
    logic       idx_neg;
    logic       count_ge_min;
    logic       count_eq_min;
    logic       head_end;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== rtl/spfh_dp.sv =====
`timescale 1ns / 1ps
module spfh_dp #(
  parameter int MAX_FRAMES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spfh_pkg::dp_cmd_t   cmd_i,
  output spfh_pkg::dp_stat_t  stat_o,
  input  spfh_pkg::in_item_t  in_data_i,
  input  logic                cfg_valid_i,
  input  logic [4:0]          cfg_data_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output spfh_pkg::out_item_t out_data_o
);

  localparam int DEPTH = MAX_FRAMES * spfh_pkg::FRAME_BYTES;
  // positions must span the reset ring size even when the memory is smaller
  localparam int SPAN_FRAMES = (MAX_FRAMES > spfh_pkg::RESET_FRAMES) ?
                               MAX_FRAMES : spfh_pkg::RESET_FRAMES;
  localparam int SPAN  = SPAN_FRAMES * spfh_pkg::FRAME_BYTES;
  localparam int POS_W = $clog2(SPAN);
  localparam int SZ_W  = $clog2(SPAN + 1);
  localparam int AW    = $clog2(DEPTH);

  spfh_pkg::in_item_t item_q;
  logic [POS_W-1:0]   rp_q, wp_q, rp_nxt, wp_nxt;
  logic [SZ_W-1:0]    size_q, size_new, count, rp_inc, wp_inc;
  logic signed [5:0]  idx_q, idx_inc, idx_wrap;
  logic [7:0]         head_q;
  logic               busy_q, ext_q, err_q;
  logic [7:0]         mem [DEPTH];
  logic [7:0]         rdata_q;
  logic               roob_q;
  logic [7:0]         frame_q [spfh_pkg::FRAME_BYTES];
  logic               out_valid_q;
  spfh_pkg::out_item_t out_q;

  logic       full, wr_in, rd_in;
  logic [7:0] put_byte, rbyte, status, out_val;

  always_comb begin
    if (cfg_data_i == 5'd0) begin
      size_new = SZ_W'(spfh_pkg::FRAME_BYTES);
    end else if (32'(cfg_data_i) > MAX_FRAMES) begin
      size_new = SZ_W'(MAX_FRAMES * spfh_pkg::FRAME_BYTES);
    end else begin
      size_new = SZ_W'(32'(cfg_data_i) * spfh_pkg::FRAME_BYTES);
    end
  end

  assign full = (SZ_W'(rp_q) == SZ_W'(wp_q) + SZ_W'(1)) ||
                ((rp_q == '0) && (SZ_W'(wp_q) == size_q - SZ_W'(1)));

  assign count = (rp_q > wp_q) ? SZ_W'(wp_q) + size_q - SZ_W'(rp_q)
                               : SZ_W'(wp_q) - SZ_W'(rp_q);

  assign wp_inc = SZ_W'(wp_q) + SZ_W'(1);
  assign rp_inc = SZ_W'(rp_q) + SZ_W'(1);
  assign wp_nxt = (wp_inc >= size_q) ? '0 : wp_inc[POS_W-1:0];
  assign rp_nxt = (rp_inc >= size_q) ? '0 : rp_inc[POS_W-1:0];

  assign wr_in = SZ_W'(wp_q) < SZ_W'(DEPTH);
  assign rd_in = SZ_W'(rp_q) < SZ_W'(DEPTH);

  always_comb begin
    case (cmd_i.put_sel)
      spfh_pkg::PUT_HEAD: put_byte = head_q;
      spfh_pkg::PUT_BYTE: put_byte = item_q.byte_in;
      default:            put_byte = 8'd0;
    endcase
  end

  // repeat count of the head decides where the next repeat run starts
  assign idx_inc  = idx_q + 6'sd1;
  assign idx_wrap = 6'sd1 - $signed({1'b0, head_q[7:3]});

  assign rbyte  = roob_q ? 8'd0 : rdata_q;
  assign status = {busy_q, busy_q & ~full, ext_q, err_q, 4'd0};

  always_comb begin
    case (cmd_i.val_sel)
      spfh_pkg::VAL_STATUS: out_val = status;
      spfh_pkg::VAL_FRAME:  out_val = frame_q[cmd_i.slot];
      default:              out_val = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      wp_q        <= '0;
      size_q      <= SZ_W'(spfh_pkg::RESET_FRAMES * spfh_pkg::FRAME_BYTES);
      idx_q       <= '0;
      head_q      <= '0;
      busy_q      <= 1'b0;
      ext_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && !busy_q) begin
        size_q <= size_new;
        rp_q   <= '0;
        wp_q   <= '0;
      end
      if (cmd_i.put && !full) begin
        wp_q <= wp_nxt;
      end
      if (cmd_i.idx_step) begin
        if (idx_q < 6'sd0) begin
          idx_q <= idx_inc;
        end else if (idx_q == 6'sd0) begin
          idx_q  <= 6'sd1;
          head_q <= item_q.byte_in;
        end else if (idx_inc >= 6'sd7) begin
          idx_q <= idx_wrap;
        end else begin
          idx_q <= idx_inc;
        end
      end
      if (cmd_i.cmd_apply) begin
        if (item_q.byte_in == spfh_pkg::CMD_STOP) begin
          busy_q <= 1'b0;
        end else if (item_q.byte_in == spfh_pkg::CMD_START) begin
          rp_q   <= '0;
          wp_q   <= '0;
          head_q <= '0;
          busy_q <= 1'b1;
          ext_q  <= 1'b1;
          err_q  <= 1'b0;
        end
      end
      if (cmd_i.pop) begin
        rp_q <= rp_nxt;
      end
      if (cmd_i.end_clr) begin
        busy_q <= 1'b0;
      end
      if (cmd_i.flush_err) begin
        rp_q   <= wp_q;
        busy_q <= 1'b0;
        err_q  <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      item_q <= in_data_i;
    end
    if (cmd_i.put && !full && wr_in) begin
      mem[wp_q[AW-1:0]] <= put_byte;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[rp_q[AW-1:0]];
      roob_q  <= ~rd_in;
    end
    if (cmd_i.pop) begin
      frame_q[cmd_i.slot] <= rbyte;
    end
    if (cmd_i.out_load) begin
      out_q.result_code <= cmd_i.out_code;
      out_q.value       <= out_val;
      out_q.last        <= cmd_i.out_last;
    end
  end

  assign stat_o.op           = item_q.op;
  assign stat_o.busy         = busy_q;
  assign stat_o.full         = full;
  assign stat_o.idx_neg      = idx_q < 6'sd0;
  assign stat_o.count_ge_min = count >= SZ_W'(spfh_pkg::FETCH_MIN);
  assign stat_o.count_eq_min = count == SZ_W'(spfh_pkg::FETCH_MIN);
  assign stat_o.head_end     = (rbyte & spfh_pkg::REPEAT_MASK) == 8'd0;
  assign stat_o.out_free     = ~out_valid_q | ~out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/spfh_ctrl.sv =====
`timescale 1ns / 1ps
module spfh_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  spfh_pkg::dp_stat_t stat_i,
  output spfh_pkg::dp_cmd_t  cmd_o,
  output logic               idle_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REP,
    S_RD,
    S_POP,
    S_EMIT,
    S_FEMIT
  } state_e;

  state_e                      state_q, state_d;
  logic [spfh_pkg::SLOT_W-1:0] k_q, k_d;
  spfh_pkg::res_e              code_q, code_d;
  spfh_pkg::val_sel_e          vsel_q, vsel_d;
  logic                        short_q, short_d;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    code_d  = code_q;
    vsel_d  = vsel_q;
    short_d = short_q;
    cmd_o   = '0;
    cmd_o.put_sel  = spfh_pkg::PUT_ZERO;
    cmd_o.out_code = spfh_pkg::RES_OK;
    cmd_o.val_sel  = spfh_pkg::VAL_ZERO;
    cmd_o.slot     = k_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        code_d  = spfh_pkg::RES_OK;
        vsel_d  = spfh_pkg::VAL_ZERO;
        k_d     = '0;
        state_d = S_EMIT;
        unique case (spfh_pkg::op_e'(stat_i.op))
          spfh_pkg::OP_DATA: begin
            if (!stat_i.busy) begin
              code_d = spfh_pkg::RES_NOT_BUSY;
            end else if (stat_i.full) begin
              code_d = spfh_pkg::RES_FULL;
            end else if (stat_i.idx_neg) begin
              state_d = S_REP;
            end else begin
              cmd_o.put      = 1'b1;
              cmd_o.put_sel  = spfh_pkg::PUT_BYTE;
              cmd_o.idx_step = 1'b1;
            end
          end
          spfh_pkg::OP_CMD: begin
            cmd_o.cmd_apply = 1'b1;
          end
          spfh_pkg::OP_STATUS: begin
            vsel_d = spfh_pkg::VAL_STATUS;
          end
          spfh_pkg::OP_FETCH: begin
            if (!stat_i.busy) begin
              code_d = spfh_pkg::RES_NOT_BUSY;
            end else if (!stat_i.count_ge_min) begin
              code_d = spfh_pkg::RES_SILENT;
            end else begin
              // exactly six held: a non-end frame runs dry on its last byte
              short_d = stat_i.count_eq_min;
              state_d = S_RD;
            end
          end
        endcase
      end
      S_REP: begin
        cmd_o.put = 1'b1;
        if (k_q == '0) begin
          cmd_o.put_sel = spfh_pkg::PUT_HEAD;
        end else if (k_q == spfh_pkg::LAST_SLOT) begin
          cmd_o.put_sel = spfh_pkg::PUT_BYTE;
        end
        if (k_q == spfh_pkg::LAST_SLOT) begin
          cmd_o.idx_step = 1'b1;
          state_d        = S_EMIT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_POP;
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        if (k_q == '0 && stat_i.head_end) begin
          cmd_o.end_clr = 1'b1;
          code_d        = spfh_pkg::RES_END;
          state_d       = S_EMIT;
        end else if (k_q == '0 && short_q) begin
          cmd_o.flush_err = 1'b1;
          code_d          = spfh_pkg::RES_ERROR;
          state_d         = S_EMIT;
        end else if (k_q == spfh_pkg::LAST_SLOT) begin
          k_d     = '0;
          state_d = S_FEMIT;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_code = code_q;
          cmd_o.val_sel  = vsel_q;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_FEMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_code = spfh_pkg::RES_FRAME;
          cmd_o.val_sel  = spfh_pkg::VAL_FRAME;
          cmd_o.out_last = (k_q == spfh_pkg::LAST_SLOT);
          if (k_q == spfh_pkg::LAST_SLOT) begin
            state_d = S_IDLE;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      code_q  <= spfh_pkg::RES_OK;
      vsel_q  <= spfh_pkg::VAL_ZERO;
      short_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      code_q  <= code_d;
      vsel_q  <= vsel_d;
      short_q <= short_d;
    end
  end

  assign idle_o = (state_q == S_IDLE);

endmodule

// ===== rtl/speech_param_fifo_host_port_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  in_data_i  (op, byte_in)
// out       output     out_valid_o/out_stall_i out_data_o (result_code, value, last)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_data_i (frames_in_buffer)
//
// One item at a time; the input reopens once the item's last result is loaded.
// A data write, command, status read, refused write or fetch, or silent frame
// gives one result. A repeat-frame write makes one ring write a cycle. A fetch
// ending in end or error gives one result. A full frame fetch does a registered
// read, then a pop, per byte, then sends the frame bytes; output stalls hold them.
// Reset clears pointers and flags and sets the ring size to 7 frames; ring
// contents are not cleared. The next item is taken while the last result waits.
`include "speech_param_fifo_host_port_core_defines.svh"
module speech_param_fifo_host_port_core #(
  parameter int MAX_FRAMES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  spfh_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output spfh_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [4:0]          cfg_data_i
);

  spfh_pkg::dp_cmd_t  dp_cmd;
  spfh_pkg::dp_stat_t dp_stat;
  logic               ctrl_idle;
  logic               in_fire;

  // input is open only while the sequencer waits for work
  assign in_stall_o = ~ctrl_idle;
  assign in_fire    = in_valid_i & ~in_stall_o;

  // register writes land only between items; the datapath ignores them while busy
  assign cfg_ready_o = ctrl_idle;

  spfh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd),
    .idle_o    (ctrl_idle)
  );

  spfh_dp #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // once an item is taken the input closes until its results are queued
  `SPFH_ASSERT_NEXT(a_accept_closes_input, in_fire, in_stall_o)
  // a result never overwrites one that is still stalled
  `SPFH_ASSERT_NOW(a_no_result_overwrite, dp_cmd.out_load, !(out_valid_o && out_stall_i))
  // every pop consumes the ring read issued the cycle before
  `SPFH_ASSERT_NOW(a_pop_after_read, dp_cmd.pop, $past(dp_cmd.rd))

endmodule

// ===== tb/spfh_answer_checker.sv =====
`timescale 1ns / 1ps
module spfh_answer_checker #(
  parameter int MAX_FRAMES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  spfh_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  spfh_pkg::out_item_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [4:0]          cfg_data_i,
  output int                  fail_cnt_o,
  output int                  pending_cnt_o,
  output int                  checked_cnt_o
);
  import spfh_pkg::*;

  localparam int RING_CAP = MAX_FRAMES * FRAME_BYTES;

  // shadow of the port state
  logic [7:0]  ring_mem [RING_CAP];
  int unsigned rd_ptr;
  int unsigned wr_ptr;
  int unsigned ring_len;
  int          frame_pos;
  logic [7:0]  head_byte;
  logic        busy_f;
  logic        ext_f;
  logic        err_f;

  out_item_t   answer_q [$];
  out_item_t   want;
  int          mismatch_cnt = 0;
  int          checked_cnt = 0;

  assign fail_cnt_o    = mismatch_cnt;
  assign checked_cnt_o = checked_cnt;

  // one slot always stays unused
  function automatic logic ring_is_full();
    return (rd_ptr == wr_ptr + 1) || (rd_ptr == 0 && wr_ptr == ring_len - 1);
  endfunction

  // bytes that meet a full ring are dropped
  task automatic ring_push(input logic [7:0] b);
    if (!ring_is_full()) begin
      ring_mem[wr_ptr] = b;
      wr_ptr++;
      if (wr_ptr >= ring_len) wr_ptr = 0;
    end
  endtask

  task automatic expect_answer(input res_e code, input logic [7:0] v, input logic fin);
    out_item_t a;
    a.result_code = code;
    a.value       = v;
    a.last        = fin;
    answer_q.push_back(a);
  endtask

  // ignored while busy; out-of-range sizes saturate
  task automatic set_ring_frames(input logic [4:0] v);
    int unsigned n;
    if (busy_f) return;
    n = v;
    if (n < 1) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    ring_len = n * FRAME_BYTES;
    rd_ptr   = 0;
    wr_ptr   = 0;
  endtask

  task automatic predict_port_answers(input in_item_t it);
    logic [7:0]  frame [FRAME_BYTES];
    logic [7:0]  d;
    logic [7:0]  status;
    int unsigned held;
    held = (rd_ptr > wr_ptr) ? wr_ptr + ring_len - rd_ptr : wr_ptr - rd_ptr;
    case (op_e'(it.op))
      OP_DATA: begin
        if (!busy_f) begin
          expect_answer(RES_NOT_BUSY, 8'h00, 1'b1);
        end else if (ring_is_full()) begin
          expect_answer(RES_FULL, 8'h00, 1'b1);
        end else begin
          if (frame_pos < 0) begin
            // repeat frame: head, five zeros, new byte
            ring_push(head_byte);
            repeat (5) ring_push(8'h00);
            ring_push(it.byte_in);
            frame_pos++;
          end else if (frame_pos == 0) begin
            ring_push(it.byte_in);
            frame_pos = 1;
            head_byte = it.byte_in;
          end else begin
            ring_push(it.byte_in);
            frame_pos++;
            if (frame_pos >= FRAME_BYTES) frame_pos = 1 - int'(head_byte >> 3);
          end
          expect_answer(RES_OK, 8'h00, 1'b1);
        end
      end
      OP_CMD: begin
        if (it.byte_in == CMD_START || it.byte_in == CMD_STOP) busy_f = 1'b0;
        if (it.byte_in == CMD_START) begin
          rd_ptr    = 0;
          wr_ptr    = 0;
          head_byte = 8'h00;
          busy_f    = 1'b1;
          ext_f     = 1'b1;
          err_f     = 1'b0;
        end
        expect_answer(RES_OK, 8'h00, 1'b1);
      end
      OP_STATUS: begin
        status = {busy_f, busy_f && !ring_is_full(), ext_f, err_f, 4'h0};
        expect_answer(RES_OK, status, 1'b1);
      end
      OP_FETCH: begin
        if (!busy_f) begin
          expect_answer(RES_NOT_BUSY, 8'h00, 1'b1);
        end else if (held < FETCH_MIN) begin
          expect_answer(RES_SILENT, 8'h00, 1'b1);
        end else begin
          for (int i = 0; i < FRAME_BYTES; i++) begin
            if (rd_ptr == wr_ptr) begin
              busy_f = 1'b0;
              err_f  = 1'b1;
              expect_answer(RES_ERROR, 8'h00, 1'b1);
              return;
            end
            d = ring_mem[rd_ptr];
            rd_ptr++;
            if (rd_ptr >= ring_len) rd_ptr = 0;
            if (i == 0 && (d & REPEAT_MASK) == 8'h00) begin
              busy_f = 1'b0;
              expect_answer(RES_END, 8'h00, 1'b1);
              return;
            end
            frame[i] = d;
          end
          for (int i = 0; i < FRAME_BYTES; i++)
            expect_answer(RES_FRAME, frame[i], i == FRAME_BYTES - 1);
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr    = 0;
      wr_ptr    = 0;
      ring_len  = RESET_FRAMES * FRAME_BYTES;
      frame_pos = 0;
      head_byte = 8'h00;
      busy_f    = 1'b0;
      ext_f     = 1'b0;
      err_f     = 1'b0;
      answer_q.delete();
      pending_cnt_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) set_ring_frames(cfg_data_i);
      if (in_valid_i && !in_stall_i) predict_port_answers(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        checked_cnt++;
        if (answer_q.size() == 0) begin
          $error("unexpected result: result_code %0d value 0x%02h last %0b",
                 out_data_i.result_code, out_data_i.value, out_data_i.last);
          mismatch_cnt++;
        end else begin
          want = answer_q.pop_front();
          if (out_data_i.result_code !== want.result_code) begin
            $error("result_code: expected %0d, got %0d",
                   want.result_code, out_data_i.result_code);
            mismatch_cnt++;
          end
          if (out_data_i.value !== want.value) begin
            $error("value: expected 0x%02h, got 0x%02h", want.value, out_data_i.value);
            mismatch_cnt++;
          end
          if (out_data_i.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data_i.last);
            mismatch_cnt++;
          end
        end
      end
      pending_cnt_o <= answer_q.size();
    end
  end

endmodule

// ===== tb/speech_param_fifo_host_port_core_test.sv =====
`timescale 1ns / 1ps
module speech_param_fifo_host_port_core_test;
  import spfh_pkg::*;

  localparam int MAX_FRAMES = 16;
  // random items per ring setting; 8 settings in all
  localparam int PHASE_ITEMS = 50;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i;

  int          fail_cnt;
  int          pending_cnt;
  int          checked_cnt;
  int unsigned items_sent = 0;
  int unsigned cfg_writes = 0;

  // shared between the sender and the receiver
  bit          no_gaps = 1'b0;
  bit          long_hold_req = 1'b0;

  speech_param_fifo_host_port_core #(
    .MAX_FRAMES (MAX_FRAMES)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // watches all three channels, predicts and compares
  spfh_answer_checker #(
    .MAX_FRAMES (MAX_FRAMES)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_i    (out_data_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fail_cnt_o    (fail_cnt),
    .pending_cnt_o (pending_cnt),
    .checked_cnt_o (checked_cnt)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // reset held low at the start, then never again
  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Idle lengths: mostly none or a few cycles, now and then a long one.
  // Zero throughout while no_gaps is set.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item, hold it until taken, then maybe idle a while.
  // With no idle, valid simply stays high for the next item.
  task automatic send_item(input op_e op, input logic [7:0] b);
    int unsigned gap;
    in_data_i  <= '{op: op, byte_in: b};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering until every predicted result has come back
  task automatic wait_answers_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  // Result side: random stall stretches, plus one long hold on request so
  // the port backs up and stalls its input.
  initial begin
    int unsigned n;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
      end else begin
        n = pick_gap();
        if (n == 0) begin
          out_stall_i <= 1'b0;
          @(posedge clk_i);
        end else begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned r;
    op_e         op;
    logic [7:0]  b;
    logic [4:0]  setting;

    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // --- directed part, reset ring size (7 frames) ---
    // not busy yet: status is all clear, writes and fetches are refused
    send_item(OP_STATUS, 8'h00);
    send_item(OP_DATA, 8'hff);
    send_item(OP_FETCH, 8'h00);
    // unknown command code does nothing
    send_item(OP_CMD, 8'h00);
    send_item(OP_CMD, CMD_START);
    send_item(OP_STATUS, 8'hff);
    // empty ring gives a silent frame
    send_item(OP_FETCH, 8'h00);
    // head with repeat count 2, then six bytes at the extremes
    send_item(OP_DATA, 8'h10);
    send_item(OP_DATA, 8'hff);
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'h55);
    send_item(OP_DATA, 8'haa);
    send_item(OP_DATA, 8'h01);
    send_item(OP_DATA, 8'h80);
    // one write past the frame expands into a repeat frame
    send_item(OP_DATA, 8'h7e);
    send_item(OP_FETCH, 8'h00);
    send_item(OP_FETCH, 8'h00);
    // head with zero repeat count: fetch pops only it and ends speech
    send_item(OP_DATA, 8'h03);
    send_item(OP_DATA, 8'h11);
    send_item(OP_DATA, 8'h22);
    send_item(OP_DATA, 8'h33);
    send_item(OP_DATA, 8'h44);
    send_item(OP_DATA, 8'h55);
    send_item(OP_FETCH, 8'h00);
    send_item(OP_STATUS, 8'h00);

    // --- random part, one phase per ring size ---
    for (int p = 0; p < 8; p++) begin
      if (p != 0) begin
        // Stop first so the size write takes effect; in phase 5 the
        // port may still be busy and the write is expected to be ignored.
        if (p != 5) send_item(OP_CMD, CMD_STOP);
        wait_answers_drained();
        // let the longest fetch finish in the core
        repeat (30) @(posedge clk_i);
        case (p)
          1:       setting = 5'd0;   // saturates to one frame
          2:       setting = 5'd31;  // saturates to MAX_FRAMES
          3:       setting = 5'd16;
          4:       setting = 5'd1;
          5:       setting = 5'd17;
          6:       setting = 5'd2;
          default: setting = 5'($urandom_range(0, 31));
        endcase
        cfg_data_i  <= setting;
        cfg_valid_i <= 1'b1;
        do @(posedge clk_i); while (!cfg_ready_o);
        cfg_valid_i <= 1'b0;
        cfg_writes++;
      end
      no_gaps = (p == 2);
      if (p == 3) long_hold_req = 1'b1;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // mid-phase pause until the port has answered everything
        if (p == 4 && k == PHASE_ITEMS / 2) wait_answers_drained();
        // Mostly a well-formed stream: data writes biased to heads with
        // small repeat counts, fetches, status, start/stop; some noise.
        r = $urandom_range(0, 99);
        b = 8'($urandom_range(0, 255));
        if (r < 12) begin
          op = op_e'($urandom_range(0, 3));
        end else if (r < 55) begin
          op = OP_DATA;
          r  = $urandom_range(0, 9);
          if (r < 6) b = 8'($urandom_range(8, 47));
          else if (r == 6) b = 8'($urandom_range(0, 7));
        end else if (r < 80) begin
          op = OP_FETCH;
        end else if (r < 88) begin
          op = OP_STATUS;
        end else begin
          op = OP_CMD;
          if (r < 95) b = CMD_START;
          else if (r < 97) b = CMD_STOP;
        end
        send_item(op, b);
      end
    end

    wait_answers_drained();
    repeat (40) @(posedge clk_i);

    $display("run: %0d items sent, %0d results checked, %0d ring size writes",
             items_sent, checked_cnt, cfg_writes);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("speech_param_fifo_host_port_core_test: clean");
    end else begin
      $display("speech_param_fifo_host_port_core_test: errors");
    end
    $finish;
  end

  // hang guard
  initial begin
    #3_000_000;
    $display("speech_param_fifo_host_port_core_test: errors");
    $finish;
  end

endmodule
